/* hdl/pnrf_pkg.sv */
package pnrf_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;

    localparam int COORD_W     = 6;
    localparam int GRID_CELLS  = 1 << (2 * COORD_W);
    localparam int ADDR_W      = $clog2(GRID_CELLS);
    localparam int CHAN_W      = 16;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int PROD_W      = CHAN_W + 8;
    localparam int OUT_CHAN_W  = 8;
    localparam int PACKED_W    = 3 * OUT_CHAN_W;
    localparam int NUM_LANES   = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hdl/peak_normalized_rgb_frame.sv */
// Frame store of 64x64 pixels with three unsigned 8.8 channels and a running peak.
// Write words (opcode 0) store a pixel and raise the peak; clear words (opcode 2) zero
// the peak; neither gives a result. A read word (opcode 1) returns each channel scaled
// as floor(c*255/peak), saturated at 255, packed as red<<16 | green<<8 | blue, or 0
// when the peak is zero or the position lies outside the frame. The frame memory is read
// at the edge that accepts the read; the load state then forms c*255 and checks
// saturation, the divide state runs three restoring dividers that each retire one
// quotient bit per cycle, and the done state loads the result into the output register.
// A read with a zero peak skips the dividers and goes straight to the done state.
// Loading waits while the output register still holds an unaccepted result. Inputs are
// not accepted while a read is in progress, so a new word is taken only after the last
// read has been loaded; a finished result is held in the output register while the next
// word is taken.
// The frame memory has no reset; reading a pixel never written gives undefined data.
module peak_normalized_rgb_frame (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_opcode,
    input  logic [pnrf_pkg::COORD_W-1:0]       s_x_pos,
    input  logic [pnrf_pkg::COORD_W-1:0]       s_y_pos,
    input  logic [pnrf_pkg::CHAN_W-1:0]        s_red_in,
    input  logic [pnrf_pkg::CHAN_W-1:0]        s_green_in,
    input  logic [pnrf_pkg::CHAN_W-1:0]        s_blue_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pnrf_pkg::PACKED_W-1:0]      m_packed_color
);
    import pnrf_pkg::*;

    logic [PIXEL_W-1:0]    frame_mem [GRID_CELLS];

    state_t                state_reg, state_next;
    logic [CHAN_W-1:0]     peak_level_reg;
    logic [PIXEL_W-1:0]    rd_data_reg;
    logic [CHAN_W-1:0]     rem_reg  [NUM_LANES];
    logic [7:0]            num_reg  [NUM_LANES];
    logic [7:0]            quot_reg [NUM_LANES];
    logic                  sat_reg  [NUM_LANES];
    logic [2:0]            count_reg;
    logic                  zero_reg;
    logic                  m_valid_reg;
    logic [PACKED_W-1:0]   m_packed_color_reg;

    logic                  accept;
    logic                  in_frame;
    logic [ADDR_W-1:0]     addr;
    logic [CHAN_W-1:0]     max_in;
    logic                  load_out;
    logic [PACKED_W-1:0]   packed_next;
    logic [CHAN_W-1:0]     chan      [NUM_LANES];
    logic [PROD_W-1:0]     prod      [NUM_LANES];
    logic [CHAN_W+1:0]     diff      [NUM_LANES];
    logic [OUT_CHAN_W-1:0] chan_out  [NUM_LANES];

    assign accept   = s_valid && s_ready;
    assign in_frame = (32'(s_x_pos) < FRAME_WIDTH) && (32'(s_y_pos) < FRAME_HEIGHT);
    assign addr     = {s_y_pos, s_x_pos};

    always_comb begin
        max_in = s_red_in;
        if (s_green_in > max_in) begin
            max_in = s_green_in;
        end
        if (s_blue_in > max_in) begin
            max_in = s_blue_in;
        end
    end

    // channel order red, green, blue in the stored word
    assign chan[0] = rd_data_reg[3*CHAN_W-1:2*CHAN_W];
    assign chan[1] = rd_data_reg[2*CHAN_W-1:CHAN_W];
    assign chan[2] = rd_data_reg[CHAN_W-1:0];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            prod[i] = {chan[i], 8'b0} - {8'b0, chan[i]};
            diff[i] = {1'b0, rem_reg[i], num_reg[i][7]} - {2'b0, peak_level_reg};
            chan_out[i] = sat_reg[i] ? 8'hFF : quot_reg[i];
        end
    end

    assign packed_next = zero_reg ? '0 : {chan_out[0], chan_out[1], chan_out[2]};

    // next state and control
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_opcode == OP_READ)) begin
                    if (in_frame && (peak_level_reg != '0)) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (count_reg == 3'd7) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // frame memory, one access per cycle
    always_ff @(posedge aclk) begin
        if (accept && (s_opcode == OP_WRITE) && in_frame) begin
            frame_mem[addr] <= {s_red_in, s_green_in, s_blue_in};
        end
        if (accept && (s_opcode == OP_READ)) begin
            rd_data_reg <= frame_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_level_reg <= '0;
        end else if (accept) begin
            if ((s_opcode == OP_WRITE) && in_frame && (max_in > peak_level_reg)) begin
                peak_level_reg <= max_in;
            end else if (s_opcode == OP_CLEAR) begin
                peak_level_reg <= '0;
            end
        end
    end

    // divider lanes
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            zero_reg  <= 1'b1;
            count_reg <= '0;
        end else if (state_reg == ST_LOAD) begin
            zero_reg  <= 1'b0;
            count_reg <= '0;
            for (int i = 0; i < NUM_LANES; i++) begin
                sat_reg[i]  <= prod[i][PROD_W-1:8] >= peak_level_reg;
                rem_reg[i]  <= (prod[i][PROD_W-1:8] >= peak_level_reg) ?
                               '0 : prod[i][PROD_W-1:8];
                num_reg[i]  <= prod[i][7:0];
                quot_reg[i] <= '0;
            end
        end else if (state_reg == ST_DIV) begin
            count_reg <= count_reg + 3'd1;
            for (int i = 0; i < NUM_LANES; i++) begin
                num_reg[i] <= {num_reg[i][6:0], 1'b0};
                if (!diff[i][CHAN_W+1]) begin
                    rem_reg[i]  <= diff[i][CHAN_W-1:0];
                    quot_reg[i] <= {quot_reg[i][6:0], 1'b1};
                end else begin
                    rem_reg[i]  <= {rem_reg[i][CHAN_W-2:0], num_reg[i][7]};
                    quot_reg[i] <= {quot_reg[i][6:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_packed_color_reg <= packed_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_packed_color = m_packed_color_reg;

    a_read_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_opcode == OP_READ) |=> state_reg != ST_IDLE)
        else $error("read word did not start a read");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_peak_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !(accept && (s_opcode == OP_CLEAR))
        |=> peak_level_reg >= $past(peak_level_reg))
        else $error("peak dropped without a clear");

    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg[0] < peak_level_reg)
            && (rem_reg[1] < peak_level_reg) && (rem_reg[2] < peak_level_reg))
        else $error("partial remainder not below the peak");

endmodule

/* dv/tb_peak_normalized_rgb_frame.sv */
`timescale 1ns / 1ps

module tb_peak_normalized_rgb_frame;
    import pnrf_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode = OP_NONE;
    logic [COORD_W-1:0]    s_x_pos = '0;
    logic [COORD_W-1:0]    s_y_pos = '0;
    logic [CHAN_W-1:0]     s_red_in = '0;
    logic [CHAN_W-1:0]     s_green_in = '0;
    logic [CHAN_W-1:0]     s_blue_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PACKED_W-1:0]   m_packed_color;

    peak_normalized_rgb_frame dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_x_pos        (s_x_pos),
        .s_y_pos        (s_y_pos),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_color (m_packed_color)
    );

    // shadow of the frame and the running peak
    logic [PIXEL_W-1:0]    shadow_frame [GRID_CELLS];
    bit                    pixel_written [GRID_CELLS];
    logic [ADDR_W-1:0]     written_cells [$];
    logic [CHAN_W-1:0]     shadow_peak = '0;
    logic [PACKED_W-1:0]   expected_colors [$];
    int                    mismatches = 0;
    bit                    no_gaps = 1'b0;
    int                    rx_stall = 0;
    int                    rx_pick;
    logic [PACKED_W-1:0]   rx_expected;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("FAIL peak_normalized_rgb_frame");
        $finish;
    end

    function automatic logic [OUT_CHAN_W-1:0] scale_to_byte(logic [CHAN_W-1:0] c);
        int unsigned q;
        q = (int'(c) * 255) / int'(shadow_peak);
        return (q > 255) ? 8'hFF : q[OUT_CHAN_W-1:0];
    endfunction

    function automatic void predict_word(opcode_t op, logic [COORD_W-1:0] x,
                                         logic [COORD_W-1:0] y, logic [CHAN_W-1:0] r,
                                         logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        logic [ADDR_W-1:0]   pix_idx;
        bit                  in_frame;
        logic [CHAN_W-1:0]   top;
        logic [PACKED_W-1:0] color;
        pix_idx = {y, x};
        in_frame = (x < FRAME_WIDTH) && (y < FRAME_HEIGHT);
        case (op)
            OP_WRITE: begin
                if (in_frame) begin
                    shadow_frame[pix_idx] = {r, g, b};
                    if (!pixel_written[pix_idx]) begin
                        pixel_written[pix_idx] = 1'b1;
                        written_cells.push_back(pix_idx);
                    end
                    top = r;
                    if (g > top) top = g;
                    if (b > top) top = b;
                    if (top > shadow_peak) shadow_peak = top;
                end
            end
            OP_READ: begin
                color = '0;
                if (in_frame && shadow_peak != 0) begin
                    color = {scale_to_byte(shadow_frame[pix_idx][3*CHAN_W-1:2*CHAN_W]),
                             scale_to_byte(shadow_frame[pix_idx][2*CHAN_W-1:CHAN_W]),
                             scale_to_byte(shadow_frame[pix_idx][CHAN_W-1:0])};
                end
                expected_colors.push_back(color);
            end
            OP_CLEAR: shadow_peak = '0;
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return CHAN_W'($urandom_range(0, 511));
            default: return CHAN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        return COORD_W'($urandom);
    endfunction

    task automatic send_word(opcode_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_x_pos    <= x;
        s_y_pos    <= y;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        predict_word(op, x, y, r, g, b);
    endtask

    task automatic send_random_write();
        send_word(OP_WRITE, random_coord(), random_coord(),
                  random_channel(), random_channel(), random_channel());
    endtask

    // reads only pixels that hold data
    task automatic send_random_read();
        logic [ADDR_W-1:0] pix_idx;
        if (written_cells.size() == 0) begin
            send_random_write();
        end else begin
            pix_idx = written_cells[$urandom_range(0, written_cells.size() - 1)];
            send_word(OP_READ, pix_idx[COORD_W-1:0], pix_idx[ADDR_W-1:COORD_W],
                      random_channel(), random_channel(), random_channel());
        end
    endtask

    task automatic wait_results_drained();
        if (expected_colors.size() != 0) begin
            s_valid <= 1'b0;
            while (expected_colors.size() != 0) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %06h",
                         $time, m_packed_color);
                mismatches++;
            end else begin
                rx_expected = expected_colors.pop_front();
                if (m_packed_color !== rx_expected) begin
                    $display("%0t: packed_color expected %06h actual %06h",
                             $time, rx_expected, m_packed_color);
                    mismatches++;
                end
            end
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (no_gaps) begin
            m_ready <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70) begin
                m_ready <= 1'b1;
            end else begin
                rx_stall = (rx_pick < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                m_ready <= 1'b0;
            end
        end
    end

    task automatic test_directed();
        send_word(OP_WRITE, 0, 0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_READ, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_WRITE, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_READ, 63, 63, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_WRITE, 0, 63, 16'h0100, 16'h0000, 16'hFFFE);
        send_word(OP_WRITE, 63, 0, 16'h5555, 16'hAAAA, 16'h0001);
        send_word(OP_READ, 0, 63, 16'h1234, 16'h5678, 16'h9ABC);
        send_word(OP_READ, 63, 0, 16'h0, 16'h0, 16'h0);
        send_word(OP_READ, 0, 0, 16'h0, 16'h0, 16'h0);
        send_word(OP_NONE, 21, 42, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_NONE, 42, 21, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_CLEAR, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // zero peak right after a clear
        send_word(OP_READ, 63, 63, 16'h0, 16'h0, 16'h0);
        send_word(OP_WRITE, 1, 0, 16'h0100, 16'h0100, 16'h0100);
        // stale pixels above the new peak saturate
        send_word(OP_READ, 63, 63, 16'h0, 16'h0, 16'h0);
        send_word(OP_READ, 63, 0, 16'h0, 16'h0, 16'h0);
        send_word(OP_READ, 1, 0, 16'h0, 16'h0, 16'h0);
        send_word(OP_WRITE, 2, 0, 16'h0080, 16'h0001, 16'h00FF);
        send_word(OP_READ, 2, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_word(OP_CLEAR, 0, 0, 16'h0, 16'h0, 16'h0);
        send_word(OP_WRITE, 3, 3, 16'h0001, 16'h0000, 16'h0000);
        send_word(OP_READ, 3, 3, 16'h0, 16'h0, 16'h0);
        send_word(OP_READ, 2, 0, 16'h0, 16'h0, 16'h0);
    endtask

    task automatic test_drain_pause();
        repeat (12) begin
            send_random_write();
            send_random_read();
        end
        wait_results_drained();
        send_random_read();
        send_word(OP_CLEAR, 0, 0, random_channel(), random_channel(), random_channel());
        send_random_write();
        send_random_read();
    endtask

    task automatic test_random_frames();
        int r;
        repeat (15) begin
            if ($urandom_range(0, 4) != 0)
                send_word(OP_CLEAR, random_coord(), random_coord(), random_channel(),
                          random_channel(), random_channel());
            repeat (60) begin
                r = $urandom_range(0, 99);
                if (r < 50) send_random_write();
                else if (r < 90) send_random_read();
                else if (r < 95) send_word(OP_NONE, random_coord(), random_coord(),
                                           random_channel(), random_channel(),
                                           random_channel());
                else send_word(OP_CLEAR, random_coord(), random_coord(), random_channel(),
                               random_channel(), random_channel());
            end
        end
    endtask

    task automatic test_back_to_back();
        wait_results_drained();
        no_gaps = 1'b1;
        repeat (50) begin
            if ($urandom_range(0, 1)) send_random_write();
            else send_random_read();
        end
        repeat (10) send_random_read();
        no_gaps = 1'b0;
        repeat (30) begin
            if ($urandom_range(0, 1)) send_random_write();
            else send_random_read();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_drain_pause();
        test_random_frames();
        test_back_to_back();
        s_valid <= 1'b0;
        wait_results_drained();
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS peak_normalized_rgb_frame");
        end else begin
            $display("FAIL peak_normalized_rgb_frame");
        end
        $finish;
    end

endmodule
